// File: hw/rtl/mwaf_pkg.sv
// Package: shared types, constants and helpers for the mosaic window fit block.
`default_nettype none
package mwaf_pkg;

  localparam int unsigned MaxDimension = 4096;
  localparam int unsigned DimW = 13;
  localparam int unsigned PosW = 14;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned QueueDepth = 2;

  localparam logic [DimW-1:0] DefWidth = 13'd1920;
  localparam logic [DimW-1:0] DefHeight = 13'd1080;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DISP_WIDTH  = 2'd0,
    REG_DISP_HEIGHT = 2'd1,
    REG_FIT_ENABLE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_FILL      = 2'd0,
    MODE_LETTERBOX = 2'd1,
    MODE_PILLARBOX = 2'd2
  } fit_mode_e;

  typedef struct packed {
    logic [5:0]      layout_code;
    logic [1:0]      window_index;
    logic [DimW-1:0] source_width;
    logic [DimW-1:0] source_height;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0] win_x;
    logic [PosW-1:0] win_y;
    logic [DimW-1:0] win_width;
    logic [DimW-1:0] win_height;
    logic [1:0]      fit_mode;
    logic [1:0]      windows_in_layout;
    logic            bad_request;
  } res_t;

  // Classified cell, handed from the front end to the fit engine.
  typedef struct packed {
    logic [DimW-1:0] cx;
    logic [DimW-1:0] cy;
    logic [DimW:0]   cw;
    logic [DimW-1:0] ch;
    logic [DimW-1:0] sw;
    logic [DimW-1:0] sh;
    logic            fit;
    logic [1:0]      count;
    logic            bad;
  } cell_t;

  function automatic logic [DimW:0] up8(input logic [DimW:0] v);
    logic [DimW+1:0] s;
    begin
      s = {1'b0, v} + (DimW+2)'(7);
      up8 = {s[DimW:3], 3'b000};
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mwaf_front.sv
// Front end: size defaults, saturation and cell classification (one register stage).
`default_nettype none
module mwaf_front #(
  parameter int unsigned MaxDim = mwaf_pkg::MaxDimension
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  mwaf_pkg::req_t              req_i,
  input  wire [mwaf_pkg::DimW-1:0]    disp_w_i,
  input  wire [mwaf_pkg::DimW-1:0]    disp_h_i,
  input  wire                         fit_i,
  output logic                        out_valid_o,
  output mwaf_pkg::cell_t             cell_o
);
  import mwaf_pkg::*;

  // A limit at or above the field range leaves every size untouched.
  localparam logic [DimW-1:0] Sat =
    (MaxDim > ((1 << DimW) - 1)) ? {DimW{1'b1}} : DimW'(MaxDim);

  logic [DimW-1:0] wd, ht, sw, sh;
  logic [DimW+1:0] w3;
  logic [DimW:0]   h2x;
  logic [DimW-1:0] w4, w2, w3d, w23, w34, h2, h3, h23;
  logic [1:0]      count;
  logic            ok;
  cell_t           c_d, c_q;
  logic            v_q;

  function automatic logic [DimW-1:0] sat(input logic [DimW-1:0] v);
    sat = (v > Sat) ? Sat : v;
  endfunction

  // Division by 3 through a reciprocal multiply, exact for 15-bit values.
  function automatic logic [DimW-1:0] div3(input logic [DimW+1:0] v);
    logic [DimW+18:0] p;
    begin
      p = {{17{1'b0}}, v} * (DimW+19)'(21846);
      div3 = p[DimW+15:16];
    end
  endfunction

  always_comb begin
    if (disp_w_i == '0 || disp_h_i == '0) begin
      wd = sat(DefWidth);
      ht = sat(DefHeight);
    end else begin
      wd = sat(disp_w_i);
      ht = sat(disp_h_i);
    end
    if (req_i.source_width == '0 || req_i.source_height == '0) begin
      sw = sat(DefWidth);
      sh = sat(DefHeight);
    end else begin
      sw = sat(req_i.source_width);
      sh = sat(req_i.source_height);
    end
    w4  = {2'b00, wd[DimW-1:2]};
    w2  = {1'b0, wd[DimW-1:1]};
    w3  = {2'b00, wd} + {1'b0, wd, 1'b0};
    w34 = w3[DimW+1:2];
    w3d = div3({2'b00, wd});
    w23 = div3({1'b0, wd, 1'b0});
    h2  = {1'b0, ht[DimW-1:1]};
    h3  = div3({2'b00, ht});
    h2x = {ht, 1'b0};
    h23 = div3({1'b0, h2x});

    if (req_i.layout_code >= 6'd10 && req_i.layout_code < 6'd20) count = 2'd1;
    else if (req_i.layout_code >= 6'd20 && req_i.layout_code < 6'd30) count = 2'd2;
    else count = 2'd3;

    c_d = '0;
    c_d.cw = up8({1'b0, wd});
    c_d.ch = ht;
    c_d.sw = sw;
    c_d.sh = sh;
    c_d.fit = fit_i;
    c_d.count = count;
    ok = 1'b0;
    case (req_i.layout_code)
      6'd11: ok = (req_i.window_index == 2'd0);
      6'd21: begin
        if (req_i.window_index == 2'd0) begin
          ok = 1'b1;
          c_d.cx = DimW'(up8({1'b0, w4}));
          c_d.cw = up8({1'b0, w34});
        end else if (req_i.window_index == 2'd1) begin
          ok = 1'b1;
          c_d.cw = up8({1'b0, w4});
          c_d.ch = h2;
        end
      end
      6'd22: begin
        ok = (req_i.window_index <= 2'd1);
        c_d.cw = up8({1'b0, w2});
        if (req_i.window_index == 2'd0) c_d.cx = DimW'(up8({1'b0, w2}));
      end
      6'd23, 6'd24, 6'd25, 6'd26: begin
        if (req_i.window_index == 2'd0) begin
          ok = 1'b1;
        end else if (req_i.window_index == 2'd1) begin
          ok = 1'b1;
          c_d.cw = up8({1'b0, w4});
          c_d.ch = h3;
          if (req_i.layout_code == 6'd24) c_d.cx = DimW'(up8({1'b0, w34}));
          if (req_i.layout_code == 6'd25) c_d.cy = h23;
          if (req_i.layout_code == 6'd26) begin
            c_d.cx = w34;
            c_d.cy = h23;
          end
        end
      end
      6'd31: begin
        if (req_i.window_index == 2'd0) begin
          ok = 1'b1;
          c_d.cw = up8({1'b0, w3d});
          c_d.ch = h2;
        end else if (req_i.window_index == 2'd1) begin
          ok = 1'b1;
          c_d.cy = h2;
          c_d.cw = up8({1'b0, w3d});
          c_d.ch = h2;
        end else if (req_i.window_index == 2'd2) begin
          ok = 1'b1;
          c_d.cx = DimW'(up8({1'b0, w3d}));
          c_d.cw = up8({1'b0, w23});
        end
      end
      6'd32: begin
        ok = (req_i.window_index <= 2'd2);
        c_d.cw = up8({1'b0, w3d});
        if (req_i.window_index == 2'd1) c_d.cx = w3d;
        if (req_i.window_index == 2'd2) c_d.cx = w23;
      end
      default: ok = 1'b0;
    endcase
    c_d.bad = !ok || ({1'b0, req_i.window_index} >= {1'b0, count});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) c_q <= c_d;
  end

  assign out_valid_o = v_q;
  assign cell_o = c_q;
endmodule
`default_nettype wire

// File: hw/rtl/mwaf_queue.sv
// Short FIFO between the classifier and the fit engine.
`default_nettype none
module mwaf_queue #(
  parameter int unsigned Depth = mwaf_pkg::QueueDepth
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  mwaf_pkg::cell_t  data_i,
  input  wire              pop_i,
  output logic             empty_o,
  output mwaf_pkg::cell_t  data_o
);
  import mwaf_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cell_t          mem_q [Depth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    nxt = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= nxt(wp_q);
      if (pop_i) rp_q <= nxt(rp_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign empty_o = (cnt_q == '0);
  assign data_o = mem_q[rp_q];
endmodule
`default_nettype wire

// File: hw/rtl/mwaf_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module mwaf_divider #(
  parameter int unsigned NumW = 26,
  parameter int unsigned DenW = 13,
  parameter int unsigned TagW = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               valid_i,
  input  wire [NumW-1:0]    num_i,
  input  wire [DenW-1:0]    den_i,
  input  wire [TagW-1:0]    tag_i,
  output logic              valid_o,
  output logic [NumW-1:0]   quo_o,
  output logic [TagW-1:0]   tag_o
);
  logic            v_q   [NumW+1];
  logic [NumW-1:0] q_q   [NumW+1];
  logic [DenW:0]   r_q   [NumW+1];
  logic [DenW-1:0] d_q   [NumW+1];
  logic [TagW-1:0] t_q   [NumW+1];

  assign v_q[0] = valid_i;
  assign q_q[0] = num_i;
  assign r_q[0] = '0;
  assign d_q[0] = den_i;
  assign t_q[0] = tag_i;

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] sh;
    logic [DenW+1:0] df;
    logic            vs_q;
    logic [NumW-1:0] qs_q;
    logic [DenW:0]   rs_q;
    logic [DenW-1:0] ds_q;
    logic [TagW-1:0] ts_q;
    assign sh = {r_q[s], q_q[s][NumW-1]};
    assign df = sh - {2'b00, d_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vs_q <= 1'b0;
      else vs_q <= v_q[s];
    end
    always_ff @(posedge clk_i) begin
      ds_q <= d_q[s];
      ts_q <= t_q[s];
      if (!df[DenW+1]) begin
        rs_q <= df[DenW:0];
        qs_q <= {q_q[s][NumW-2:0], 1'b1};
      end else begin
        rs_q <= sh[DenW:0];
        qs_q <= {q_q[s][NumW-2:0], 1'b0};
      end
    end
    assign v_q[s+1] = vs_q;
    assign q_q[s+1] = qs_q;
    assign r_q[s+1] = rs_q;
    assign d_q[s+1] = ds_q;
    assign t_q[s+1] = ts_q;
  end

  assign valid_o = v_q[NumW];
  assign quo_o = q_q[NumW];
  assign tag_o = t_q[NumW];
endmodule
`default_nettype wire

// File: hw/rtl/mwaf_back.sv
// Fit engine: aspect compare, divide, floor to even and centering.
`default_nettype none
module mwaf_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  input  mwaf_pkg::cell_t  cell_i,
  output logic             valid_o,
  output mwaf_pkg::res_t   res_o
);
  import mwaf_pkg::*;

  localparam int unsigned NumW = 2 * DimW + 1;
  localparam int unsigned TagW = $bits(cell_t) + 2;

  // Stage 1: cross products.
  logic [NumW-1:0] lhs_q, rhs_q;
  cell_t           c1_q;
  logic            v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    c1_q  <= cell_i;
    lhs_q <= NumW'({{DimW{1'b0}}, cell_i.sw} * {{DimW{1'b0}}, cell_i.ch});
    rhs_q <= NumW'({{(DimW-1){1'b0}}, cell_i.cw} * {{DimW{1'b0}}, cell_i.sh});
  end

  // Stage 2: choose mode and divide operands.
  fit_mode_e       mode;
  logic [NumW-1:0] num;
  logic [DimW-1:0] den;
  logic [TagW-1:0] tag_in, tag_out;
  logic [NumW-1:0] quo;
  logic            dv;

  always_comb begin
    mode = MODE_FILL;
    num = '0;
    den = DimW'(1);
    if (c1_q.fit && !c1_q.bad) begin
      if (lhs_q > rhs_q) begin
        mode = MODE_LETTERBOX;
        num = rhs_q;
        den = c1_q.sw;
      end else if (lhs_q < rhs_q) begin
        mode = MODE_PILLARBOX;
        num = NumW'({{DimW{1'b0}}, c1_q.ch} * {{DimW{1'b0}}, c1_q.sw});
        den = c1_q.sh;
      end
    end
    tag_in = {c1_q, mode};
  end

  mwaf_divider #(.NumW(NumW), .DenW(DimW), .TagW(TagW)) u_div (
    .clk_i, .rst_ni,
    .valid_i (v1_q),
    .num_i   (num),
    .den_i   (den),
    .tag_i   (tag_in),
    .valid_o (dv),
    .quo_o   (quo),
    .tag_o   (tag_out)
  );

  cell_t           c3;
  fit_mode_e       m3;
  logic [DimW:0]   ow;
  logic [DimW-1:0] oh;
  logic [DimW:0]   dx;
  logic [DimW-1:0] dy;
  res_t            r_d, r_q;
  logic            v_q;

  always_comb begin
    c3 = tag_out[TagW-1:2];
    m3 = fit_mode_e'(tag_out[1:0]);
    ow = c3.cw;
    oh = c3.ch;
    case (m3)
      MODE_LETTERBOX: begin
        oh = {quo[DimW-1:1], 1'b0};
        ow = {c3.cw[DimW:1], 1'b0};
      end
      MODE_PILLARBOX: begin
        ow = {quo[DimW:1], 1'b0};
        oh = {c3.ch[DimW-1:1], 1'b0};
      end
      default: ;
    endcase
    dx = c3.cw - ow;
    dy = c3.ch - oh;
    r_d = '0;
    r_d.windows_in_layout = c3.count;
    r_d.bad_request = c3.bad;
    if (!c3.bad) begin
      r_d.win_x = PosW'({1'b0, c3.cx} + {1'b0, up8({1'b0, dx[DimW:1]})});
      r_d.win_y = PosW'({1'b0, c3.cy} + {1'b0, 1'b0, dy[DimW-1:1]});
      r_d.win_width = ow[DimW-1:0];
      r_d.win_height = oh;
      r_d.fit_mode = m3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else v_q <= dv;
  end
  always_ff @(posedge clk_i) begin
    if (dv) r_q <= r_d;
  end

  assign valid_o = v_q;
  assign res_o = r_q;
endmodule
`default_nettype wire

// File: hw/rtl/mosaic_window_aspect_fit.sv
// Top level: mosaic window rectangle with aspect-preserving fit.
// Pipeline from an accepted request to its result strobe: classify register,
// queue, multiply register, 27 divider stages, output register.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset: asynchronous active low; registers return to 1920x1080 with fit on.
// The receiver cannot stall: each result is shown for exactly one cycle on done_o.
`default_nettype none
module mosaic_window_aspect_fit #(
  parameter int unsigned MaxDim = mwaf_pkg::MaxDimension
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // request side
  input  wire                            start,
  output logic                           busy,
  input  mwaf_pkg::req_t                 req_i,
  // result side
  output logic                           done_o,
  output mwaf_pkg::res_t                 res_o,
  // register writes
  input  wire                            cfg_we_i,
  input  wire [mwaf_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire [mwaf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mwaf_pkg::*;

  logic [DimW-1:0] disp_w_q, disp_h_q;
  logic            fit_q;
  logic            acc;
  logic            fv;
  cell_t           fcell, qcell;
  logic            qempty, pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q <= DefWidth;
      disp_h_q <= DefHeight;
      fit_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_DISP_WIDTH:  disp_w_q <= cfg_data_i;
        REG_DISP_HEIGHT: disp_h_q <= cfg_data_i;
        REG_FIT_ENABLE:  fit_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Fully pipelined: a request is taken every cycle.
  assign busy = 1'b0;
  assign acc = start && !busy;

  mwaf_front #(.MaxDim(MaxDim)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (acc),
    .req_i,
    .disp_w_i   (disp_w_q),
    .disp_h_i   (disp_h_q),
    .fit_i      (fit_q),
    .out_valid_o(fv),
    .cell_o     (fcell)
  );

  // The fit engine never stalls, so the queue drains each cycle it holds data.
  assign pop = !qempty;

  mwaf_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (fv),
    .data_i  (fcell),
    .pop_i   (pop),
    .empty_o (qempty),
    .data_o  (qcell)
  );

  mwaf_back u_back (
    .clk_i, .rst_ni,
    .valid_i (pop),
    .cell_i  (qcell),
    .valid_o (done_o),
    .res_o
  );
endmodule
`default_nettype wire
